### design/gpiorb_pkg.sv
// Shared types and fixed constants of the GPIO register bank.
package gpiorb_pkg;

   // Word index inside one array window of the register map
   localparam int WIN_IDX_W = 8;

   // Reset values of the fixed registers
   localparam logic [31:0] STRAP_RESET = 32'h0000_0012;
   localparam logic [31:0] IN0_RESET   = 32'h0000_0001;
   localparam logic [31:0] IN1_RESET   = 32'h0000_0008;

   // Fields of a pin config word
   localparam int INT_TYPE_LSB = 7;
   localparam int INT_TYPE_MSB = 9;
   localparam int PRO_EN_BIT   = 15;
   localparam int APP_EN_BIT   = 13;

   // Interrupt type codes; other codes never trigger
   localparam logic [2:0] INT_RISE = 3'd1;
   localparam logic [2:0] INT_FALL = 3'd2;
   localparam logic [2:0] INT_ANY  = 3'd3;
   localparam logic [2:0] INT_LOW  = 3'd4;
   localparam logic [2:0] INT_HIGH = 3'd5;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_PIN   = 2'd2
   } req_type_type;

   typedef enum logic [4:0] {
      REG_NONE,
      REG_OUT,
      REG_OUT_W1TS,
      REG_OUT_W1TC,
      REG_EN,
      REG_EN_W1TS,
      REG_EN_W1TC,
      REG_STRAP,
      REG_IN0,
      REG_IN1,
      REG_STS0,
      REG_STS0_W1TS,
      REG_STS0_W1TC,
      REG_STS1,
      REG_STS1_W1TS,
      REG_STS1_W1TC,
      REG_APP0,
      REG_PRO0,
      REG_APP1,
      REG_PRO1,
      REG_PIN_CFG,
      REG_IN_SEL,
      REG_OUT_SEL
   } reg_kind_type;

   typedef struct packed {
      reg_kind_type           kind;
      logic [WIN_IDX_W-1:0]   idx;
   } decode_type;

endpackage

### design/gpio_register_bank_with_pin_interrupts_top.sv
// GPIO register bank with pin interrupts: bus register access and pin level events.
// Every transaction (bus read, bus write or pin level change) runs in an accept step
// and an execute step: the first reads the per-pin config / output-select memory or the
// input-select memory through its registered read port, the second does the
// read-modify-write of the state and loads the response register. A new transaction is
// not taken while one is in the execute step. A response waiting in its register stalls
// only the second step of the next transaction. Per-entry valid bits make the memories
// read as zero after reset, so no clearing pass is needed. The status clear check uses
// per-pin level-type flags kept beside the config memory.
module gpio_register_bank_with_pin_interrupts_top
   import gpiorb_pkg::*;
#(
   parameter int NUM_PINS           = 40,
   parameter int IN_SELECT_ENTRIES  = 256,
   parameter int OUT_SELECT_ENTRIES = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic [5:0]  req_pin_number,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_line,
   output logic [31:0] rsp_out_word,
   output logic [31:0] rsp_enable_word,
   output logic        rsp_out_changed,
   output logic        rsp_enable_changed
);

   // Config memory holds pin config words, then output-select words
   localparam int CFG_DEPTH = NUM_PINS + OUT_SELECT_ENTRIES;
   localparam int CFG_AW    = $clog2(CFG_DEPTH);
   localparam int SEL_AW    = (IN_SELECT_ENTRIES > 1) ? $clog2(IN_SELECT_ENTRIES) : 1;
   localparam int PIN_W     = $clog2(NUM_PINS);

   // Architectural state
   logic [31:0]          out_ff, out_in;
   logic [31:0]          en_ff, en_in;
   logic [31:0]          strap_ff, strap_in;
   logic [1:0][31:0]     in_lvl_ff, in_lvl_in;
   logic [1:0][31:0]     sts_ff, sts_in;
   logic [1:0][31:0]     pro_ff, pro_in;
   logic [1:0][31:0]     app_ff, app_in;
   logic                 irq_ff, irq_in;
   logic [NUM_PINS-1:0]  lvl_low_ff;
   logic [NUM_PINS-1:0]  lvl_high_ff;

   // Memories and their valid bits
   logic [31:0]                  cfg_mem [CFG_DEPTH];
   logic [31:0]                  sel_mem [IN_SELECT_ENTRIES];
   logic [CFG_DEPTH-1:0]         cfg_vld_ff;
   logic [IN_SELECT_ENTRIES-1:0] sel_vld_ff;
   logic [31:0]                  cfg_rd_ff, sel_rd_ff;
   logic                         cfg_rv_ff, sel_rv_ff;

   // Execute stage
   logic                 ex_vld_ff;
   logic [1:0]           ex_req_ff;
   decode_type           ex_dec_ff;
   logic [31:0]          ex_data_ff;
   logic [5:0]           ex_pin_ff;
   logic                 ex_lvl_ff;
   logic                 ex_hit_ff;
   logic [CFG_AW-1:0]    ex_cfg_addr_ff;
   logic [SEL_AW-1:0]    ex_sel_addr_ff;

   // Response register
   logic                 rsp_vld_ff;
   logic [31:0]          rsp_rdata_ff;
   logic                 rsp_irq_ff;
   logic [31:0]          rsp_out_ff;
   logic [31:0]          rsp_en_ff;
   logic                 rsp_oc_ff;
   logic                 rsp_ec_ff;

   // Accept side
   decode_type           acc_dec;
   logic                 req_accept;
   logic                 acc_hit;
   logic [CFG_AW-1:0]    cfg_raddr;
   logic [SEL_AW-1:0]    sel_raddr;

   // Execute side
   logic                 ex_done;
   logic [31:0]          cfg_word, sel_word;
   logic [31:0]          rdata;
   logic                 cfg_we, sel_we, flag_we;
   logic [2:0]           pin_int_type;
   logic                 pin_bank, pin_old, pin_fire;
   logic [4:0]           pin_bit;
   logic [1:0][31:0]     low_bank, high_bank;
   logic                 clr_bank;
   logic [31:0]          clr_block;
   logic                 clr_refuse;
   logic [PIN_W-1:0]     flag_idx;

   gpiorb_decode u_decode (
      .address (req_address),
      .dec     (acc_dec)
   );

   assign req_stall  = ex_vld_ff;
   assign req_accept = req_valid && !req_stall;
   assign ex_done    = ex_vld_ff && (!rsp_vld_ff || !rsp_stall);

   // Memory read addresses for the incoming transaction
   always_comb begin
      acc_hit   = 1'b0;
      cfg_raddr = '0;
      sel_raddr = '0;
      if (req_type == REQ_PIN) begin
         acc_hit = {1'b0, req_pin_number} < 7'(NUM_PINS);
         if (acc_hit) begin
            cfg_raddr = CFG_AW'(req_pin_number);
         end
      end else begin
         unique case (acc_dec.kind)
            REG_PIN_CFG: begin
               acc_hit = {1'b0, acc_dec.idx} < 9'(NUM_PINS);
               if (acc_hit) begin
                  cfg_raddr = CFG_AW'(acc_dec.idx);
               end
            end
            REG_OUT_SEL: begin
               acc_hit = {1'b0, acc_dec.idx} < 9'(OUT_SELECT_ENTRIES);
               if (acc_hit) begin
                  cfg_raddr = CFG_AW'(NUM_PINS) + CFG_AW'(acc_dec.idx);
               end
            end
            REG_IN_SEL: begin
               acc_hit = {1'b0, acc_dec.idx} < 9'(IN_SELECT_ENTRIES);
               if (acc_hit) begin
                  sel_raddr = SEL_AW'(acc_dec.idx);
               end
            end
            default: acc_hit = 1'b0;
         endcase
      end
   end

   // Entries never written read as zero
   assign cfg_word = cfg_rv_ff ? cfg_rd_ff : '0;
   assign sel_word = sel_rv_ff ? sel_rd_ff : '0;

   // Pin event decode
   assign pin_bank     = ex_pin_ff[5];
   assign pin_bit      = ex_pin_ff[4:0];
   assign pin_old      = in_lvl_ff[pin_bank][pin_bit];
   assign pin_int_type = cfg_word[INT_TYPE_MSB:INT_TYPE_LSB];

   always_comb begin
      unique case (pin_int_type)
         INT_RISE: pin_fire = ex_lvl_ff && !pin_old;
         INT_FALL: pin_fire = !ex_lvl_ff && pin_old;
         INT_ANY:  pin_fire = ex_lvl_ff != pin_old;
         INT_LOW:  pin_fire = !ex_lvl_ff;
         INT_HIGH: pin_fire = ex_lvl_ff;
         default:  pin_fire = 1'b0;
      endcase
   end

   // Status clear is refused while a selected level-type pin is still active
   assign low_bank   = 64'(lvl_low_ff);
   assign high_bank  = 64'(lvl_high_ff);
   assign clr_bank   = (ex_dec_ff.kind == REG_STS1_W1TC);
   assign clr_block  = (low_bank[clr_bank] & ~in_lvl_ff[clr_bank])
                     | (high_bank[clr_bank] & in_lvl_ff[clr_bank]);
   assign clr_refuse = |(clr_block & ex_data_ff);
   assign flag_idx   = PIN_W'(ex_dec_ff.idx);

   // Read-modify-write of the state
   always_comb begin
      out_in    = out_ff;
      en_in     = en_ff;
      strap_in  = strap_ff;
      in_lvl_in = in_lvl_ff;
      sts_in    = sts_ff;
      pro_in    = pro_ff;
      app_in    = app_ff;
      irq_in    = irq_ff;
      rdata     = '0;
      cfg_we    = 1'b0;
      sel_we    = 1'b0;
      flag_we   = 1'b0;
      unique case (ex_req_ff)
         REQ_READ: begin
            unique case (ex_dec_ff.kind)
               REG_OUT:     rdata = out_ff;
               REG_EN:      rdata = en_ff;
               REG_STRAP:   rdata = strap_ff;
               REG_IN0:     rdata = in_lvl_ff[0];
               REG_IN1:     rdata = in_lvl_ff[1];
               REG_STS0:    rdata = sts_ff[0];
               REG_STS1:    rdata = sts_ff[1];
               REG_APP0:    rdata = app_ff[0];
               REG_PRO0:    rdata = pro_ff[0];
               REG_APP1:    rdata = app_ff[1];
               REG_PRO1:    rdata = pro_ff[1];
               REG_PIN_CFG: rdata = ex_hit_ff ? cfg_word : '0;
               REG_OUT_SEL: rdata = ex_hit_ff ? cfg_word : '0;
               REG_IN_SEL:  rdata = ex_hit_ff ? sel_word : '0;
               default:     rdata = '0;
            endcase
         end
         REQ_WRITE: begin
            unique case (ex_dec_ff.kind)
               REG_OUT:       out_in    = ex_data_ff;
               REG_OUT_W1TS:  out_in    = out_ff | ex_data_ff;
               REG_OUT_W1TC:  out_in    = out_ff & ~ex_data_ff;
               REG_EN:        en_in     = ex_data_ff;
               REG_EN_W1TS:   en_in     = en_ff | ex_data_ff;
               REG_EN_W1TC:   en_in     = en_ff & ~ex_data_ff;
               REG_STRAP:     strap_in  = ex_data_ff;
               REG_STS0:      sts_in[0] = ex_data_ff;
               REG_STS0_W1TS: sts_in[0] = sts_ff[0] | ex_data_ff;
               REG_STS1:      sts_in[1] = ex_data_ff;
               REG_STS1_W1TS: sts_in[1] = sts_ff[1] | ex_data_ff;
               REG_STS0_W1TC, REG_STS1_W1TC: begin
                  if (!clr_refuse) begin
                     sts_in[clr_bank] = sts_ff[clr_bank] & ~ex_data_ff;
                     pro_in[clr_bank] = pro_ff[clr_bank] & ~ex_data_ff;
                     app_in[clr_bank] = app_ff[clr_bank] & ~ex_data_ff;
                     irq_in           = 1'b0;
                  end
               end
               REG_PIN_CFG: begin
                  cfg_we  = ex_hit_ff;
                  flag_we = ex_hit_ff;
               end
               REG_OUT_SEL:   cfg_we = ex_hit_ff;
               REG_IN_SEL:    sel_we = ex_hit_ff;
               default:       cfg_we = 1'b0;
            endcase
         end
         REQ_PIN: begin
            if (ex_hit_ff) begin
               in_lvl_in[pin_bank][pin_bit] = ex_lvl_ff;
               if (pin_fire) begin
                  irq_in = 1'b1;
                  if (cfg_word[PRO_EN_BIT]) begin
                     pro_in[pin_bank][pin_bit] = 1'b1;
                  end
                  if (cfg_word[APP_EN_BIT]) begin
                     app_in[pin_bank][pin_bit] = 1'b1;
                  end
               end
            end
         end
         default: rdata = '0;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         out_ff      <= '0;
         en_ff       <= '0;
         strap_ff    <= STRAP_RESET;
         in_lvl_ff   <= {IN1_RESET, IN0_RESET};
         sts_ff      <= '0;
         pro_ff      <= '0;
         app_ff      <= '0;
         irq_ff      <= 1'b0;
         lvl_low_ff  <= '0;
         lvl_high_ff <= '0;
         cfg_vld_ff  <= '0;
         sel_vld_ff  <= '0;
      end else begin
         if (req_accept) begin
            ex_vld_ff <= 1'b1;
         end else if (ex_done) begin
            ex_vld_ff <= 1'b0;
         end
         if (ex_done) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
         if (ex_done) begin
            out_ff    <= out_in;
            en_ff     <= en_in;
            strap_ff  <= strap_in;
            in_lvl_ff <= in_lvl_in;
            sts_ff    <= sts_in;
            pro_ff    <= pro_in;
            app_ff    <= app_in;
            irq_ff    <= irq_in;
            if (cfg_we) begin
               cfg_vld_ff[ex_cfg_addr_ff] <= 1'b1;
            end
            if (sel_we) begin
               sel_vld_ff[ex_sel_addr_ff] <= 1'b1;
            end
            // Keep the level-type flags in step with the config word
            if (flag_we) begin
               lvl_low_ff[flag_idx]  <= ex_data_ff[INT_TYPE_MSB:INT_TYPE_LSB] == INT_LOW;
               lvl_high_ff[flag_idx] <= ex_data_ff[INT_TYPE_MSB:INT_TYPE_LSB] == INT_HIGH;
            end
         end
      end
   end

   // Execute stage and response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ex_req_ff      <= req_type;
         ex_dec_ff      <= acc_dec;
         ex_data_ff     <= req_write_data;
         ex_pin_ff      <= req_pin_number;
         ex_lvl_ff      <= req_pin_level;
         ex_hit_ff      <= acc_hit;
         ex_cfg_addr_ff <= cfg_raddr;
         ex_sel_addr_ff <= sel_raddr;
      end
      if (ex_done) begin
         rsp_rdata_ff <= rdata;
         rsp_irq_ff   <= irq_in;
         rsp_out_ff   <= out_in;
         rsp_en_ff    <= en_in;
         rsp_oc_ff    <= out_in != out_ff;
         rsp_ec_ff    <= en_in != en_ff;
      end
   end

   // Config / output-select memory
   always_ff @(posedge clock) begin
      if (ex_done && cfg_we) begin
         cfg_mem[ex_cfg_addr_ff] <= ex_data_ff;
      end
      if (req_accept) begin
         cfg_rd_ff <= cfg_mem[cfg_raddr];
         cfg_rv_ff <= cfg_vld_ff[cfg_raddr];
      end
   end

   // Input-select memory
   always_ff @(posedge clock) begin
      if (ex_done && sel_we) begin
         sel_mem[ex_sel_addr_ff] <= ex_data_ff;
      end
      if (req_accept) begin
         sel_rd_ff <= sel_mem[sel_raddr];
         sel_rv_ff <= sel_vld_ff[sel_raddr];
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_read_data      = rsp_rdata_ff;
   assign rsp_irq_line       = rsp_irq_ff;
   assign rsp_out_word       = rsp_out_ff;
   assign rsp_enable_word    = rsp_en_ff;
   assign rsp_out_changed    = rsp_oc_ff;
   assign rsp_enable_changed = rsp_ec_ff;

   // Level-type flags agree with the config word read for a pin event
   a_flag_shadow: assert property (@(posedge clock) disable iff (reset)
      ex_vld_ff && ex_req_ff == REQ_PIN && ex_hit_ff |->
         lvl_low_ff[PIN_W'(ex_pin_ff)] == (pin_int_type == INT_LOW) &&
         lvl_high_ff[PIN_W'(ex_pin_ff)] == (pin_int_type == INT_HIGH))
      else $error("pin level-type flags out of step with config memory");

   a_irq_fire: assert property (@(posedge clock) disable iff (reset)
      ex_done && ex_req_ff == REQ_PIN && ex_hit_ff && pin_fire |=> irq_ff && rsp_irq_line)
      else $error("triggered pin did not raise irq");

   a_input_levels: assert property (@(posedge clock) disable iff (reset)
      ex_done && ex_req_ff != REQ_PIN |=> $stable(in_lvl_ff))
      else $error("input levels changed outside a pin event");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(ex_vld_ff))
      else $error("response raised without a transaction in execute");

endmodule

### design/gpiorb_decode.sv
// Register map decode: byte offset to register kind and array word index.
module gpiorb_decode
   import gpiorb_pkg::*;
(
   input  logic [11:0] address,
   output decode_type  dec
);

   localparam logic [11:0] ADDR_OUT       = 12'h004;
   localparam logic [11:0] ADDR_OUT_W1TS  = 12'h008;
   localparam logic [11:0] ADDR_OUT_W1TC  = 12'h00C;
   localparam logic [11:0] ADDR_EN        = 12'h020;
   localparam logic [11:0] ADDR_EN_W1TS   = 12'h024;
   localparam logic [11:0] ADDR_EN_W1TC   = 12'h028;
   localparam logic [11:0] ADDR_STRAP     = 12'h038;
   localparam logic [11:0] ADDR_IN0       = 12'h03C;
   localparam logic [11:0] ADDR_IN1       = 12'h040;
   localparam logic [11:0] ADDR_STS0      = 12'h044;
   localparam logic [11:0] ADDR_STS0_W1TS = 12'h048;
   localparam logic [11:0] ADDR_STS0_W1TC = 12'h04C;
   localparam logic [11:0] ADDR_STS1      = 12'h050;
   localparam logic [11:0] ADDR_STS1_W1TS = 12'h054;
   localparam logic [11:0] ADDR_STS1_W1TC = 12'h058;
   localparam logic [11:0] ADDR_APP0      = 12'h060;
   localparam logic [11:0] ADDR_PRO0      = 12'h068;
   localparam logic [11:0] ADDR_APP1      = 12'h074;
   localparam logic [11:0] ADDR_PRO1      = 12'h07C;
   localparam logic [11:0] LOW_END        = 12'h088;
   localparam logic [11:0] PIN_END        = 12'h130;
   localparam logic [11:0] INSEL_END      = 12'h530;
   localparam logic [11:0] OUTSEL_END     = 12'h5D0;

   logic [11:0] offset;

   always_comb begin
      dec.kind = REG_NONE;
      dec.idx  = '0;
      offset   = '0;
      priority if (address < LOW_END) begin
         unique case (address)
            ADDR_OUT:       dec.kind = REG_OUT;
            ADDR_OUT_W1TS:  dec.kind = REG_OUT_W1TS;
            ADDR_OUT_W1TC:  dec.kind = REG_OUT_W1TC;
            ADDR_EN:        dec.kind = REG_EN;
            ADDR_EN_W1TS:   dec.kind = REG_EN_W1TS;
            ADDR_EN_W1TC:   dec.kind = REG_EN_W1TC;
            ADDR_STRAP:     dec.kind = REG_STRAP;
            ADDR_IN0:       dec.kind = REG_IN0;
            ADDR_IN1:       dec.kind = REG_IN1;
            ADDR_STS0:      dec.kind = REG_STS0;
            ADDR_STS0_W1TS: dec.kind = REG_STS0_W1TS;
            ADDR_STS0_W1TC: dec.kind = REG_STS0_W1TC;
            ADDR_STS1:      dec.kind = REG_STS1;
            ADDR_STS1_W1TS: dec.kind = REG_STS1_W1TS;
            ADDR_STS1_W1TC: dec.kind = REG_STS1_W1TC;
            ADDR_APP0:      dec.kind = REG_APP0;
            ADDR_PRO0:      dec.kind = REG_PRO0;
            ADDR_APP1:      dec.kind = REG_APP1;
            ADDR_PRO1:      dec.kind = REG_PRO1;
            default:        dec.kind = REG_NONE;
         endcase
      end else if (address < PIN_END) begin
         offset   = address - LOW_END;
         dec.kind = REG_PIN_CFG;
         dec.idx  = offset[WIN_IDX_W+1:2];
      end else if (address < INSEL_END) begin
         offset   = address - PIN_END;
         dec.kind = REG_IN_SEL;
         dec.idx  = offset[WIN_IDX_W+1:2];
      end else if (address < OUTSEL_END) begin
         offset   = address - INSEL_END;
         dec.kind = REG_OUT_SEL;
         dec.idx  = offset[WIN_IDX_W+1:2];
      end else begin
         dec.kind = REG_NONE;
      end
   end

endmodule
